@@ rtl/dsf_pkg.sv @@
// Package with the control codes, the packet number limits, the queue size and the descriptor.
`default_nettype none
package dsf_pkg;

  localparam logic [7:0] CODE_SOH  = 8'h01;
  localparam logic [7:0] CODE_EOT  = 8'h04;
  localparam logic [7:0] CODE_ACK  = 8'h06;
  localparam logic [7:0] CODE_DLE  = 8'h10;
  localparam logic [7:0] CODE_NACK = 8'h15;
  localparam logic [7:0] NUM_RESET = 8'd127;
  localparam logic [7:0] NUM_WRAP  = 8'd128;
  localparam logic [7:0] NUM_TOP   = 8'd255;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // One accepted payload byte, already classified by the front end.
  typedef struct packed {
    logic       open_soh;
    logic       esc_data;
    logic [7:0] data;
    logic       close;
    logic [7:0] num;
    logic       esc_par;
    logic [7:0] par;
  } desc_t;

  function automatic logic is_control(input logic [7:0] b);
    is_control = (b == CODE_SOH) || (b == CODE_EOT) || (b == CODE_ACK) ||
                 (b == CODE_DLE) || (b == CODE_NACK);
  endfunction

endpackage
`default_nettype wire

@@ rtl/dsf_in_if.sv @@
// Interface for the payload item channel.
`default_nettype none
interface dsf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       packet_end;

  modport source (output valid, output payload_byte, output packet_end, input ready);
  modport sink (input valid, input payload_byte, input packet_end, output ready);
endinterface
`default_nettype wire

@@ rtl/dsf_out_if.sv @@
// Interface for the line byte item channel.
`default_nettype none
interface dsf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] line_byte;
  logic       run_last;

  modport source (output valid, output line_byte, output run_last, input ready);
  modport sink (input valid, input line_byte, input run_last, output ready);
endinterface
`default_nettype wire

@@ rtl/dle_stuffed_packet_framer.sv @@
// Top level of the DLE byte-stuffing packet framer with XOR checksum.
//
//   Channel   Direction  Payload
//   payload   sink       payload_byte[7:0], packet_end
//   line      source     line_byte[7:0], run_last
//
// The back end sends one line byte per cycle while the line sink takes them, and an
// item causes one line byte for a plain byte, up to seven for an escaped byte
// that opens and closes a packet. The front end accepts an item in every cycle
// while the two-entry descriptor queue has room. Synchronous reset empties the
// queue and output register and sets the packet number to 127.
`default_nettype none
module dle_stuffed_packet_framer
  import dsf_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  dsf_in_if.sink    payload,
  dsf_out_if.source line
);

  desc_t push_desc;
  desc_t head;
  logic  push;
  logic  full;
  logic  pop;
  logic  head_valid;

  dsf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .payload   (payload),
    .push_desc (push_desc),
    .push      (push),
    .full      (full)
  );

  dsf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_desc  (push_desc),
    .full       (full),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid)
  );

  dsf_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .line       (line)
  );

endmodule
`default_nettype wire

@@ rtl/dsf_front.sv @@
// Front end: accepts payload items, keeps packet state and builds framing descriptors.
`default_nettype none
module dsf_front
  import dsf_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  dsf_in_if.sink    payload,
  output desc_t     push_desc,
  output logic      push,
  input  wire logic full
);

  logic [7:0] packet_number;
  logic [7:0] running_parity;
  logic       inside_packet;
  logic [7:0] parity_acc;
  logic [7:0] parity_final;

  assign payload.ready = !full;
  assign push          = payload.valid && !full;

  assign parity_acc   = inside_packet ? (running_parity ^ payload.payload_byte)
                                      : payload.payload_byte;
  assign parity_final = parity_acc ^ packet_number;

  always_comb begin
    push_desc.open_soh = !inside_packet;
    push_desc.esc_data = is_control(payload.payload_byte);
    push_desc.data     = payload.payload_byte;
    push_desc.close    = payload.packet_end;
    push_desc.num      = packet_number;
    push_desc.esc_par  = is_control(parity_final);
    push_desc.par      = parity_final;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      packet_number  <= NUM_RESET;
      running_parity <= '0;
      inside_packet  <= 1'b0;
    end else if (push) begin
      if (payload.packet_end) begin
        packet_number  <= (packet_number == NUM_TOP) ? NUM_WRAP : packet_number + 8'd1;
        running_parity <= '0;
        inside_packet  <= 1'b0;
      end else begin
        running_parity <= parity_acc;
        inside_packet  <= 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/dsf_queue.sv @@
// Short descriptor queue between the front end and the back end.
`default_nettype none
module dsf_queue
  import dsf_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  wire desc_t push_desc,
  output logic       full,
  input  wire logic  pop,
  output desc_t      head,
  output logic       head_valid
);

  desc_t                entries [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]  wr_ptr;
  logic [QUEUE_AW-1:0]  rd_ptr;
  logic [QUEUE_AW:0]    count;

  assign full       = (count == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QUEUE_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QUEUE_AW'(1);
      end
      if (push && !pop) begin
        count <= count + (QUEUE_AW+1)'(1);
      end else if (pop && !push) begin
        count <= count - (QUEUE_AW+1)'(1);
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/dsf_back.sv @@
// Back end: steps through a descriptor and sends one line byte per cycle while the line sink takes them.
`default_nettype none
module dsf_back
  import dsf_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire desc_t head,
  input  wire logic  head_valid,
  output logic       pop,
  dsf_out_if.source  line
);

  localparam logic [2:0] ST_SOH   = 3'd0;
  localparam logic [2:0] ST_DLE_D = 3'd1;
  localparam logic [2:0] ST_DATA  = 3'd2;
  localparam logic [2:0] ST_NUM   = 3'd3;
  localparam logic [2:0] ST_DLE_P = 3'd4;
  localparam logic [2:0] ST_PAR   = 3'd5;
  localparam logic [2:0] ST_EOT   = 3'd6;

  logic [2:0] step;
  logic       started;
  logic [2:0] step_cur;
  logic [2:0] step_next;
  logic       done;
  logic [7:0] byte_cur;
  logic       load;
  logic       out_valid;
  logic [7:0] out_byte;
  logic       out_last;

  assign load = head_valid && (!out_valid || line.ready);
  assign pop  = load && done;

  always_comb begin
    if (started) begin
      step_cur = step;
    end else if (head.open_soh) begin
      step_cur = ST_SOH;
    end else if (head.esc_data) begin
      step_cur = ST_DLE_D;
    end else begin
      step_cur = ST_DATA;
    end
  end

  always_comb begin
    step_next = ST_DATA;
    done      = 1'b0;
    byte_cur  = head.data;
    case (step_cur)
      ST_SOH: begin
        byte_cur  = CODE_SOH;
        step_next = head.esc_data ? ST_DLE_D : ST_DATA;
      end
      ST_DLE_D: begin
        byte_cur  = CODE_DLE;
        step_next = ST_DATA;
      end
      ST_DATA: begin
        byte_cur  = head.data;
        step_next = ST_NUM;
        done      = !head.close;
      end
      ST_NUM: begin
        byte_cur  = head.num;
        step_next = head.esc_par ? ST_DLE_P : ST_PAR;
      end
      ST_DLE_P: begin
        byte_cur  = CODE_DLE;
        step_next = ST_PAR;
      end
      ST_PAR: begin
        byte_cur  = head.par;
        step_next = ST_EOT;
      end
      ST_EOT: begin
        byte_cur = CODE_EOT;
        done     = 1'b1;
      end
      default: begin
        byte_cur = CODE_EOT;
        done     = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      started   <= 1'b0;
      step      <= ST_SOH;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        started   <= !done;
        step      <= step_next;
        out_valid <= 1'b1;
      end else if (line.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte <= byte_cur;
      out_last <= done;
    end
  end

  assign line.valid     = out_valid;
  assign line.line_byte = out_byte;
  assign line.run_last  = out_last;

endmodule
`default_nettype wire
